// ===== rtl/core/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and helpers for the base64 stream decoder
// Holds the classified-character type passed from front to back, the
// queue sizing and the alphabet lookup.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef enum logic [1:0] {
        KIND_SYM = 2'd0,
        KIND_PAD = 2'd1,
        KIND_BAD = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [5:0] sextet;
        logic       last;
    } t_cls_item;

    // Map one character to its class and six-bit value.
    function automatic t_cls_item classify(input logic [7:0] c, input logic last);
        t_cls_item r;
        logic [7:0] v;
        r.kind   = KIND_BAD;
        r.sextet = 6'd0;
        r.last   = last;
        v        = 8'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            v      = c - 8'h41;
            r.kind = KIND_SYM;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            v      = c - 8'h61 + 8'd26;
            r.kind = KIND_SYM;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v      = c - 8'h30 + 8'd52;
            r.kind = KIND_SYM;
        end else if (c == 8'h2B) begin
            v      = 8'd62;
            r.kind = KIND_SYM;
        end else if (c == 8'h2F) begin
            v      = 8'd63;
            r.kind = KIND_SYM;
        end else if (c == PAD_CHAR) begin
            r.kind = KIND_PAD;
        end
        r.sextet = v[5:0];
        return r;
    endfunction

endpackage

// ===== rtl/core/base64_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// base64_stream_decoder: one-character-per-beat base64 decoder
// Path: an input beat is registered in the queue, then in the output register.
// Throughput: one character per cycle while i_ready does not stall the output;
// the group state update in the assembler is the loop that sets this rate.
// Reset: synchronous, active low; clears the queue, the group state and the
// output valid flag. No clearing pass is needed.
// ----------------------------------------------------------------------------
module base64_stream_decoder
    import b64d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // character channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_in,
    input  logic       i_last,
    // result channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_byte_valid,
    output logic [7:0] o_data_byte,
    output logic       o_bad_char,
    output logic       o_end_of_stream
);

    // Front -> queue: classified character beats.
    logic      w_q_push;
    t_cls_item w_push_item;
    logic      w_q_full;

    // Queue -> back: oldest pending beat.
    logic      w_q_pop;
    logic      w_q_nonempty;
    t_cls_item w_pop_item;

    // Classify each character as symbol, pad or bad; stall only on a full queue.
    b64d_front u_front (
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_char_in (i_char_in),
        .i_last    (i_last),
        .i_q_full  (w_q_full),
        .o_q_push  (w_q_push),
        .o_q_item  (w_push_item)
    );

    // Decouple intake from output back-pressure.
    b64d_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_q_push),
        .i_item     (w_push_item),
        .o_full     (w_q_full),
        .i_pop      (w_q_pop),
        .o_nonempty (w_q_nonempty),
        .o_item     (w_pop_item)
    );

    // Track the group of four, assemble bytes and hold the result beat
    // until it is taken; a new beat is popped in the same cycle.
    b64d_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_nonempty    (w_q_nonempty),
        .i_q_item        (w_pop_item),
        .o_q_pop         (w_q_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_byte_valid    (o_byte_valid),
        .o_data_byte     (o_data_byte),
        .o_bad_char      (o_bad_char),
        .o_end_of_stream (o_end_of_stream)
    );

endmodule

// ===== rtl/core/b64d_front.sv =====
// ----------------------------------------------------------------------------
// b64d_front: character intake and classification
// Accepts one character beat, looks it up in the alphabet and hands the
// classified item to the queue.
// ----------------------------------------------------------------------------
module b64d_front
    import b64d_pkg::*;
(
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_in,
    input  logic       i_last,
    input  logic       i_q_full,
    output logic       o_q_push,
    output t_cls_item  o_q_item
);

    // Take a beat whenever the queue has room.
    assign o_ready  = !i_q_full;
    assign o_q_push = i_valid && !i_q_full;
    assign o_q_item = classify(i_char_in, i_last);

endmodule

// ===== rtl/core/b64d_queue.sv =====
// ----------------------------------------------------------------------------
// b64d_queue: short FIFO between classifier and assembler
// Stores classified items; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module b64d_queue
    import b64d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_cls_item  i_item,
    output logic       o_full,
    input  logic       i_pop,
    output logic       o_nonempty,
    output t_cls_item  o_item
);

    t_cls_item                r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CNT_W-1:0]   r_count, n_count;

    assign o_full     = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_item     = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== rtl/core/b64d_back.sv =====
// ----------------------------------------------------------------------------
// b64d_back: group tracking and byte assembly
// Pops classified items, advances the group state and registers one
// result per item.
// ----------------------------------------------------------------------------
module b64d_back
    import b64d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_nonempty,
    input  t_cls_item  i_q_item,
    output logic       o_q_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_byte_valid,
    output logic [7:0] o_data_byte,
    output logic       o_bad_char,
    output logic       o_end_of_stream
);

    logic [1:0] r_pos, n_pos;
    logic [5:0] r_prev, n_prev;
    logic       r_pad, n_pad;
    logic       r_out_valid;
    logic       r_byte_valid, n_byte_valid;
    logic [7:0] r_data_byte, n_data_byte;
    logic       r_bad_char, n_bad_char;
    logic       r_eos;

    assign o_q_pop = i_q_nonempty && (!r_out_valid || i_ready);

    always_comb begin
        n_pos        = r_pos;
        n_prev       = r_prev;
        n_pad        = r_pad;
        n_byte_valid = 1'b0;
        n_data_byte  = 8'd0;
        n_bad_char   = 1'b0;
        if (r_pos == 2'd3 && r_pad) begin
            // Swallow the character after a position-2 pad.
            n_pos = 2'd0;
            n_pad = 1'b0;
        end else begin
            unique case (i_q_item.kind)
                KIND_PAD: begin
                    if (r_pos == 2'd2) begin
                        n_pad = 1'b1;
                        n_pos = 2'd3;
                    end else if (r_pos == 2'd3) begin
                        n_pos = 2'd0;
                        n_pad = 1'b0;
                    end else begin
                        n_bad_char = 1'b1;
                    end
                end
                KIND_SYM: begin
                    unique case (r_pos)
                        2'd1: n_data_byte = {r_prev, i_q_item.sextet[5:4]};
                        2'd2: n_data_byte = {r_prev[3:0], i_q_item.sextet[5:2]};
                        2'd3: n_data_byte = {r_prev[1:0], i_q_item.sextet};
                        default: n_data_byte = 8'd0;
                    endcase
                    n_byte_valid = (r_pos != 2'd0);
                    n_prev       = i_q_item.sextet;
                    n_pos        = r_pos + 2'd1;
                    if (r_pos == 2'd3) begin
                        n_pad = 1'b0;
                    end
                end
                default: begin
                    n_bad_char = 1'b1;
                end
            endcase
        end
        // Drop leftovers at the end of a string.
        if (i_q_item.last) begin
            n_pos  = 2'd0;
            n_prev = 6'd0;
            n_pad  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= 2'd0;
            r_prev      <= 6'd0;
            r_pad       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_pos       <= n_pos;
                r_prev      <= n_prev;
                r_pad       <= n_pad;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_byte_valid <= n_byte_valid;
            r_data_byte  <= n_data_byte;
            r_bad_char   <= n_bad_char;
            r_eos        <= i_q_item.last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_byte_valid    = r_byte_valid;
    assign o_data_byte     = r_data_byte;
    assign o_bad_char      = r_bad_char;
    assign o_end_of_stream = r_eos;

endmodule
